// ----- sv/fqrs_pkg.sv -----
// Shared types and codes for the queue block with reverse and search.
// Used by fqrs_ctrl, fqrs_dpath and fifo_queue_reverse_search_core.
package fqrs_pkg;

    localparam int DATA_W  = 24;
    localparam int BYTES_W = 3;     // entry bytes compared by search
    localparam int INDEX_W = 3;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_REMOVE  = 2'd1;
    localparam logic [1:0] MODE_REVERSE = 2'd2;
    localparam logic [1:0] MODE_SEARCH  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [DATA_W-1:0] entry_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [DATA_W-1:0]  data_out;
        logic [INDEX_W-1:0] found_index;
        logic               is_empty;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take the input item this cycle
        logic read;     // read the entry at walk position
        logic check;    // evaluate the entry read last cycle
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk;     // input item needs a walk over the store
        logic last;     // this check finishes the item
    } t_dp_sts;

endpackage

// ----- sv/fqrs_ctrl.sv -----
// Sequencer for the queue block: handshakes and walk sequencing.
// Depends on fqrs_pkg.
module fqrs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fqrs_pkg::t_dp_cmd o_cmd,
    input  fqrs_pkg::t_dp_sts i_sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_out_valid = (r_state == S_OUT);
    assign o_in_stall  = !((r_state == S_IDLE) || ((r_state == S_OUT) && !i_out_stall));
    assign accept      = i_in_valid && !o_in_stall;

    assign o_cmd.accept = accept;
    assign o_cmd.read   = (r_state == S_READ);
    assign o_cmd.check  = (r_state == S_CHECK);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_sts.walk ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_sts.last ? S_OUT : S_READ;
            end
            S_OUT: begin
                if (accept) begin
                    n_state = i_sts.walk ? S_READ : S_OUT;
                end else if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/fqrs_dpath.sv -----
// Datapath for the queue block: entry ring, pointers, compare and result register.
// Depends on fqrs_pkg.
module fqrs_dpath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fqrs_pkg::t_in_item  i_in,
    input  fqrs_pkg::t_dp_cmd   i_cmd,
    output fqrs_pkg::t_dp_sts   o_sts,
    output fqrs_pkg::t_out_item o_out
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [fqrs_pkg::DATA_W-1:0] r_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]            r_head;
    logic [CNT_W-1:0]            r_count;
    logic                        r_rev;
    logic [PTR_W-1:0]            r_k;
    logic [1:0]                  r_mode;
    logic [fqrs_pkg::DATA_W-1:0] r_key;
    logic [fqrs_pkg::DATA_W-1:0] r_rd;
    fqrs_pkg::t_out_item         r_res;

    logic [PTR_W-1:0]   n_head;
    logic [CNT_W-1:0]   n_count;
    logic               n_rev;
    logic [PTR_W-1:0]   n_k;
    fqrs_pkg::t_out_item n_res;

    logic               empty;
    logic               full;
    logic               do_write;
    logic [PTR_W-1:0]   wr_slot;
    logic [CNT_W-1:0]   count_m1;
    logic [CNT_W-1:0]   k_next_c;
    logic [PTR_W+2:0]   k_ext;
    logic               hit;
    logic               stop;
    logic               last_pos;

    // ring slot of logical position off from the head, walking in the current direction
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] hd,
                                                 input logic rv,
                                                 input logic [PTR_W-1:0] off);
        logic [PTR_W:0] s;
        begin
            if (rv) begin
                s = {1'b0, hd} - {1'b0, off};
                if (s[PTR_W]) begin
                    s = s + DEPTH_P;
                end
            end else begin
                s = {1'b0, hd} + {1'b0, off};
                if (s >= DEPTH_P) begin
                    s = s - DEPTH_P;
                end
            end
            slot_of = s[PTR_W-1:0];
        end
    endfunction

    assign empty    = (r_count == '0);
    assign full     = (r_count == DEPTH_C);
    assign count_m1 = r_count - CNT_W'(1);
    assign k_next_c = CNT_W'(r_k) + CNT_W'(1);
    assign k_ext    = {3'b000, r_k};
    assign last_pos = (k_next_c == r_count);
    assign wr_slot  = slot_of(r_head, r_rev, r_count[PTR_W-1:0]);
    assign do_write = i_cmd.accept && (i_in.mode == fqrs_pkg::MODE_INSERT) && !full;

    // byte compare up to and including the first zero byte of the stored entry
    always_comb begin
        hit  = 1'b1;
        stop = 1'b0;
        for (int b = 0; b < fqrs_pkg::BYTES_W; b++) begin
            if (!stop) begin
                if (r_rd[8*b +: 8] != r_key[8*b +: 8]) begin
                    hit  = 1'b0;
                    stop = 1'b1;
                end else if (r_rd[8*b +: 8] == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end
    end

    assign o_sts.walk = !empty && ((i_in.mode == fqrs_pkg::MODE_REMOVE) ||
                                   (i_in.mode == fqrs_pkg::MODE_SEARCH));
    assign o_sts.last = (r_mode == fqrs_pkg::MODE_REMOVE) || hit || last_pos;

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_rev   = r_rev;
        n_k     = r_k;
        n_res   = r_res;
        if (i_cmd.accept) begin
            n_k                = '0;
            n_res.status       = fqrs_pkg::ST_OK;
            n_res.data_out     = '0;
            n_res.found_index  = '0;
            n_res.is_empty     = empty;
            case (i_in.mode)
                fqrs_pkg::MODE_INSERT: begin
                    if (full) begin
                        n_res.status = fqrs_pkg::ST_FULL;
                    end else begin
                        n_count        = r_count + CNT_W'(1);
                        n_res.is_empty = 1'b0;
                    end
                end
                fqrs_pkg::MODE_REMOVE: begin
                    if (empty) begin
                        n_res.status = fqrs_pkg::ST_EMPTY;
                    end
                end
                fqrs_pkg::MODE_REVERSE: begin
                    if (!empty) begin
                        n_head = slot_of(r_head, r_rev, count_m1[PTR_W-1:0]);
                        n_rev  = !r_rev;
                    end
                end
                default: begin
                    n_res.status = fqrs_pkg::ST_NOT_FOUND;
                end
            endcase
        end else if (i_cmd.check) begin
            if (r_mode == fqrs_pkg::MODE_REMOVE) begin
                n_res.data_out = r_rd;
                n_head         = slot_of(r_head, r_rev, PTR_W'(1));
                n_count        = count_m1;
                n_res.is_empty = (count_m1 == '0);
            end else if (hit) begin
                n_res.status      = fqrs_pkg::ST_OK;
                n_res.found_index = k_ext[fqrs_pkg::INDEX_W-1:0];
            end else if (!last_pos) begin
                n_k = k_next_c[PTR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_res <= n_res;
        if (i_cmd.accept) begin
            r_mode <= i_in.mode;
            r_key  <= i_in.entry_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[wr_slot] <= i_in.entry_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd <= r_mem[slot_of(r_head, r_rev, r_k)];
        end
    end

    assign o_out = r_res;

endmodule

// ----- sv/fifo_queue_reverse_search_core.sv -----
// Bounded queue of 24-bit entries with insert, remove, reverse and search.
// Insert, reverse and any op on an empty queue register the result at accept; remove does one
//   read/check pair; search does read/check pairs up to the matched position or the last entry.
// Items are taken one at a time; the search walk reads one ring slot per read/check pair
//   through the single registered read port of the entry store.
// Reset (i_rst_n, synchronous, active low): queue empty, head at slot 0, forward order.
module fifo_queue_reverse_search_core #(
    parameter int QUEUE_DEPTH = 8       // ring slots, 2 to 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fqrs_pkg::t_in_item  i_in,
    // result item channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fqrs_pkg::t_out_item o_out
);

    // Controller and datapath talk only through these two groups.
    fqrs_pkg::t_dp_cmd cmd;
    fqrs_pkg::t_dp_sts sts;

    // Controller: accepts an item when idle or as the held result leaves,
    // then steps read/check pairs until the datapath reports the last one.
    fqrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Datapath: entry ring, head/count/direction, byte compare, result register.
    // Reverse swaps head to the old tail and flips direction; no data moves.
    fqrs_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule
